// ===== rtl/core/rle_coefficient_temporal_decoder_top_macros.svh =====
// Assertion helpers shared by the decoder RTL.
`ifndef RLE_COEFFICIENT_TEMPORAL_DECODER_TOP_MACROS_SVH
`define RLE_COEFFICIENT_TEMPORAL_DECODER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RLECTD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rlectd same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define RLECTD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rlectd next-cycle check failed");

`endif

// ===== rtl/core/rlectd_pkg.sv =====
package rlectd_pkg;

  // Width of the internal run accumulator.
  localparam int unsigned RUN_BITS    = 31;
  localparam int unsigned OUT_RUN_W   = 31;
  localparam int unsigned COEF_W      = 14;
  localparam int unsigned SYM_W       = 8;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned IN_TUSER_W  = 1;
  localparam int unsigned RES_W       = COEF_W + 1 + OUT_RUN_W + 1;
  localparam int unsigned OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

  localparam logic [63:0] OUT_RUN_MAX = (64'd1 << OUT_RUN_W) - 64'd1;

  // Declared high to low so that coefficient lands in the lowest bits.
  typedef struct packed {
    logic                        run_overflow;
    logic [OUT_RUN_W-1:0]        run_length;
    logic                        temporal_signal;
    logic signed [COEF_W-1:0]    coefficient;
  } result_t;

endpackage

// ===== rtl/core/rlectd_decode.sv =====
module rlectd_decode (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_mode_i,
  input  logic                         in_fire_i,
  input  logic [rlectd_pkg::SYM_W-1:0] symbol_byte_i,
  input  logic                         chunk_start_i,
  output logic                         res_valid_o,
  output rlectd_pkg::result_t          res_o
);
  import rlectd_pkg::*;

  localparam logic [1:0] PH_LSB  = 2'd0;
  localparam logic [1:0] PH_MSB  = 2'd1;
  localparam logic [1:0] PH_RUN  = 2'd2;
  localparam logic [1:0] PH_RSVD = 2'd3;

  logic                mode_q, mode_d;
  logic [1:0]          phase_q, phase_d;
  logic [COEF_W-1:0]   held_q, held_d;
  logic [RUN_BITS-1:0] acc_q, acc_d;
  logic                sat_q, sat_d;
  logic                tstate_q, tstate_d;
  logic                first_q, first_d;

  // State as seen after an optional chunk restart.
  logic [1:0]          phase_c;
  logic [COEF_W-1:0]   held_c;
  logic [RUN_BITS-1:0] acc_c;
  logic                sat_c;
  logic                first_c;

  logic [RUN_BITS-1:0] acc_grow;
  logic                sat_grow;
  logic [63:0]         acc_ext;
  logic [COEF_W-1:0]   coef_v;
  logic [5:0]          short_v;

  always_comb begin
    phase_c = chunk_start_i ? PH_LSB : phase_q;
    held_c  = chunk_start_i ? '0 : held_q;
    acc_c   = chunk_start_i ? '0 : acc_q;
    sat_c   = chunk_start_i ? 1'b0 : sat_q;
    first_c = chunk_start_i ? 1'b0 : first_q;
  end

  // Shift in one 7-bit run group, pinning at the maximum once the top would spill.
  always_comb begin
    sat_grow = sat_c || (acc_c[RUN_BITS-1 -: 7] != 7'd0);
    acc_grow = sat_grow ? '1 : {acc_c[RUN_BITS-8:0], symbol_byte_i[6:0]};
    acc_ext  = 64'(acc_grow);
  end

  always_comb begin
    short_v = {~symbol_byte_i[6], symbol_byte_i[5:1]};
    if (phase_c == PH_MSB) begin
      coef_v = {~symbol_byte_i[6], symbol_byte_i[5:0], held_c[7:1]};
    end else begin
      coef_v = {{(COEF_W-6){short_v[5]}}, short_v};
    end
  end

  always_comb begin
    mode_d      = mode_q;
    phase_d     = phase_q;
    held_d      = held_q;
    acc_d       = acc_q;
    sat_d       = sat_q;
    tstate_d    = tstate_q;
    first_d     = first_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (cfg_we_i) begin
      mode_d  = cfg_mode_i;
      phase_d = PH_LSB;
      held_d  = '0;
      acc_d   = '0;
      sat_d   = 1'b0;
      first_d = 1'b0;
    end else if (in_fire_i) begin
      phase_d = phase_c;
      held_d  = held_c;
      acc_d   = acc_c;
      sat_d   = sat_c;
      first_d = first_c;
      if (mode_q) begin
        if (!first_c) begin
          first_d  = 1'b1;
          tstate_d = symbol_byte_i[0];
        end else begin
          acc_d = acc_grow;
          sat_d = sat_grow;
          if (!symbol_byte_i[7]) begin
            res_valid_o           = 1'b1;
            res_o.temporal_signal = tstate_q;
            res_o.run_length      = (acc_ext > OUT_RUN_MAX) ? OUT_RUN_W'(OUT_RUN_MAX)
                                                            : OUT_RUN_W'(acc_grow);
            res_o.run_overflow    = sat_grow || (acc_ext > OUT_RUN_MAX);
            tstate_d              = ~tstate_q;
            acc_d                 = '0;
            sat_d                 = 1'b0;
          end
        end
      end else begin
        unique case (phase_c)
          PH_RUN: begin
            acc_d = acc_grow;
            sat_d = sat_grow;
            if (!symbol_byte_i[7]) begin
              res_valid_o        = 1'b1;
              res_o.coefficient  = held_c;
              res_o.run_length   = (acc_ext > OUT_RUN_MAX) ? OUT_RUN_W'(OUT_RUN_MAX)
                                                           : OUT_RUN_W'(acc_grow);
              res_o.run_overflow = sat_grow || (acc_ext > OUT_RUN_MAX);
              phase_d            = PH_LSB;
              held_d             = '0;
              acc_d              = '0;
              sat_d              = 1'b0;
            end
          end
          PH_LSB, PH_MSB, PH_RSVD: begin
            if (phase_c != PH_MSB && symbol_byte_i[0]) begin
              // Long value: hold the low byte until the high byte arrives.
              held_d  = COEF_W'({symbol_byte_i[7:1], 1'b0});
              phase_d = PH_MSB;
            end else begin
              acc_d = '0;
              sat_d = 1'b0;
              if (symbol_byte_i[7]) begin
                held_d  = coef_v;
                phase_d = PH_RUN;
              end else begin
                res_valid_o       = 1'b1;
                res_o.coefficient = coef_v;
                phase_d           = PH_LSB;
                held_d            = '0;
              end
            end
          end
          default: begin
            phase_d = PH_LSB;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      phase_q  <= PH_LSB;
      held_q   <= '0;
      acc_q    <= '0;
      sat_q    <= 1'b0;
      tstate_q <= 1'b0;
      first_q  <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      phase_q  <= phase_d;
      held_q   <= held_d;
      acc_q    <= acc_d;
      sat_q    <= sat_d;
      tstate_q <= tstate_d;
      first_q  <= first_d;
    end
  end

`include "rle_coefficient_temporal_decoder_top_macros.svh"

  `RLECTD_ASSERT_NOW(a_phase_legal, 1'b1, phase_q != PH_RSVD)
  `RLECTD_ASSERT_NOW(a_temporal_no_phase, mode_q, phase_q == PH_LSB)
  `RLECTD_ASSERT_NOW(a_sat_pins_max, sat_q, acc_q == {RUN_BITS{1'b1}})

endmodule

// ===== rtl/core/rle_coefficient_temporal_decoder_top.sv =====
// The result of the byte that completes a group is registered into the output stage.
// Throughput: one byte per cycle while tready is high; decode is a single combinational
// pass on the parse state. A two-entry output stage (register plus skid) keeps s_axis_tready
// high through an output stall until the skid entry fills; tready drops while the skid entry
// is occupied or cfg_valid_i is high. Reset (rst_ni low, asynchronous) clears mode to
// coefficient, the parse state and the output stage; bytes are taken once reset is released.
module rle_coefficient_temporal_decoder_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic                               cfg_data_i,     // decode_mode
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [rlectd_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i, // symbol_byte
  input  logic [rlectd_pkg::IN_TUSER_W-1:0]  s_axis_tuser_i, // chunk_start
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // m_axis_tdata_o: coefficient, temporal_signal, run_length, run_overflow, zero pad
  output logic [rlectd_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);
  import rlectd_pkg::*;

  logic    in_fire;
  logic    res_valid;
  result_t res;
  logic    pop;

  logic    out_v_q, out_v_d;
  result_t out_q, out_d;
  logic    skid_v_q, skid_v_d;
  result_t skid_q, skid_d;

  assign cfg_ready_o     = 1'b1;
  // Hold input items off while a mode write lands so no byte is dropped.
  assign s_axis_tready_o = !skid_v_q && !cfg_valid_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  rlectd_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i),
    .cfg_mode_i    (cfg_data_i),
    .in_fire_i     (in_fire),
    .symbol_byte_i (s_axis_tdata_i[SYM_W-1:0]),
    .chunk_start_i (s_axis_tuser_i[0]),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  assign pop = out_v_q && m_axis_tready_i;

  always_comb begin
    out_v_d  = out_v_q;
    out_d    = out_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (!out_v_q) begin
      out_v_d = res_valid;
      out_d   = res;
    end else if (pop) begin
      if (skid_v_q) begin
        // Advance the skid item; the new item takes its place.
        out_d    = skid_q;
        skid_v_d = res_valid;
        skid_d   = res;
      end else begin
        out_v_d = res_valid;
        out_d   = res;
      end
    end else if (res_valid) begin
      skid_v_d = 1'b1;
      skid_d   = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'(out_q);

`include "rle_coefficient_temporal_decoder_top_macros.svh"

  `RLECTD_ASSERT_NOW(a_skid_behind_out, skid_v_q, out_v_q)
  `RLECTD_ASSERT_NEXT(a_skid_drains, skid_v_q && m_axis_tready_i, m_axis_tvalid_o)
  `RLECTD_ASSERT_NOW(a_no_result_unless_fire, res_valid, in_fire)

endmodule

// ===== sim/tb.sv =====
module tb;

  typedef rlectd_pkg::result_t result_t;

  typedef enum logic {
    MODE_COEF     = 1'b0,
    MODE_TEMPORAL = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    PH_LSB = 2'd0,
    PH_MSB = 2'd1,
    PH_RUN = 2'd2
  } phase_e;

  // ROW_CFG writes symbol[0] as decode_mode; ROW_RES and ROW_NONE carry a typed
  // expectation; ROW_PRED leaves it to the decoder model below.
  typedef enum logic [1:0] {
    ROW_CFG  = 2'd0,
    ROW_PRED = 2'd1,
    ROW_RES  = 2'd2,
    ROW_NONE = 2'd3
  } row_kind_e;

  typedef struct packed {
    row_kind_e kind;
    logic [7:0] symbol;
    logic       start;
    result_t    res;
  } row_t;

  localparam logic [63:0] RUN_FULL    = (64'd1 << rlectd_pkg::RUN_BITS) - 64'd1;
  localparam int          IDLE_LIMIT  = 1000;
  localparam int          PHASES      = 8;
  localparam int          PHASE_ITEMS = 160;
  localparam logic [7:0]  PHASE_MODES = 8'b1101_0010;

  logic                                clk_i;
  logic                                rst_ni = 1'b0;
  logic                                cfg_valid_i = 1'b0;
  logic                                cfg_ready_o;
  logic                                cfg_data_i = 1'b0;
  logic                                s_axis_tvalid_i = 1'b0;
  logic                                s_axis_tready_o;
  logic [rlectd_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i = '0;  // symbol_byte
  logic [rlectd_pkg::IN_TUSER_W-1:0]   s_axis_tuser_i = '0;  // chunk_start
  logic                                m_axis_tvalid_o;
  logic                                m_axis_tready_i = 1'b0;
  // coefficient, temporal_signal, run_length, run_overflow, zero pad
  logic [rlectd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o;

  rle_coefficient_temporal_decoder_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Decoder model state
  mode_e       dec_mode;
  phase_e      dec_phase;
  logic [13:0] held_part;
  logic [63:0] run_acc;
  logic        run_sat;
  logic        tmp_state;
  logic        first_seen;

  result_t pending_results[$];
  int      error_count;
  int      phase_items;
  bit      tx_idle_on;
  bit      rx_idle_on;
  int      long_hold_cycles;
  int      idle_cycles;

  task automatic report_error(input string what);
    if (error_count < 50) $display("ERROR at %0t: %s", $time, what);
    error_count++;
  endtask

  function automatic void clear_parse();
    dec_phase  = PH_LSB;
    held_part  = '0;
    run_acc    = '0;
    run_sat    = 1'b0;
    first_seen = 1'b0;
  endfunction

  function automatic void add_run_group(input logic [7:0] b);
    if (run_sat || run_acc > (RUN_FULL >> 7)) begin
      run_acc = RUN_FULL;
      run_sat = 1'b1;
    end else begin
      run_acc = (run_acc << 7) | {57'd0, b[6:0]};
    end
  endfunction

  function automatic result_t close_run(input logic [13:0] coef, input logic tsig);
    result_t r;
    logic [63:0] run;
    logic        ovf;
    run = run_acc;
    ovf = run_sat;
    if (run > rlectd_pkg::OUT_RUN_MAX) begin
      run = rlectd_pkg::OUT_RUN_MAX;
      ovf = 1'b1;
    end
    r.coefficient     = coef;
    r.temporal_signal = tsig;
    r.run_length      = run[30:0];
    r.run_overflow    = ovf;
    run_acc = '0;
    run_sat = 1'b0;
    return r;
  endfunction

  // Advance the model by one byte; return 1 when a group completes.
  function automatic bit decode_symbol(input logic [7:0] b, input logic start,
                                       output result_t r);
    logic [15:0] long_val;
    logic [13:0] v;
    logic        tsig;
    r = '0;
    if (start) clear_parse();
    if (dec_mode == MODE_TEMPORAL) begin
      if (!first_seen) begin
        first_seen = 1'b1;
        tmp_state  = b[0];
        return 1'b0;
      end
      add_run_group(b);
      if (b[7]) return 1'b0;
      tsig      = tmp_state;
      tmp_state = ~tmp_state;
      r = close_run(14'd0, tsig);
      return 1'b1;
    end
    case (dec_phase)
      PH_MSB: begin
        long_val = ({1'b0, b[6:0], held_part[7:0]} >> 1) - 16'h2000;
        v = long_val[13:0];
      end
      PH_RUN: begin
        add_run_group(b);
        if (b[7]) return 1'b0;
        dec_phase = PH_LSB;
        v = held_part;
        held_part = '0;
        r = close_run(v, 1'b0);
        return 1'b1;
      end
      default: begin
        if (b[0]) begin
          held_part = {6'd0, b[7:1], 1'b0};
          dec_phase = PH_MSB;
          return 1'b0;
        end
        v = {8'd0, b[6:1]} - 14'd32;
      end
    endcase
    if (b[7]) begin
      held_part = v;
      run_acc   = '0;
      run_sat   = 1'b0;
      dec_phase = PH_RUN;
      return 1'b0;
    end
    dec_phase = PH_LSB;
    held_part = '0;
    run_acc   = '0;
    run_sat   = 1'b0;
    r = close_run(v, 1'b0);
    return 1'b1;
  endfunction

  function automatic row_t mk_row(input row_kind_e kind, input logic [7:0] symbol,
                                  input logic start, input int coef, input logic tsig,
                                  input logic [30:0] run, input logic ovf);
    row_t row;
    row.kind                = kind;
    row.symbol              = symbol;
    row.start               = start;
    row.res.coefficient     = coef[13:0];
    row.res.temporal_signal = tsig;
    row.res.run_length      = run;
    row.res.run_overflow    = ovf;
    return row;
  endfunction

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic mode);
    s_axis_tvalid_i <= 1'b0;
    wait_drained();
    // let a byte that completes no group settle before the write
    repeat (3) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= mode;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    dec_mode = mode_e'(mode);
    clear_parse();
  endtask

  task automatic send_row(input row_t row);
    int      gap;
    result_t r;
    bit      got;
    gap = tx_idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= row.symbol;
    s_axis_tuser_i  <= row.start;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    got = decode_symbol(row.symbol, row.start, r);
    case (row.kind)
      ROW_RES:  pending_results.push_back(row.res);
      ROW_PRED: if (got) pending_results.push_back(r);
      default: ;
    endcase
    phase_items++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic start);
    send_row(mk_row(ROW_PRED, b, start, 0, 1'b0, 31'd0, 1'b0));
  endtask

  // Number of 7-bit run bytes; the tail reaches saturation.
  function automatic int pick_run_count();
    int r;
    r = $urandom_range(0, 19);
    if (r < 8) return 0;
    if (r < 17) return $urandom_range(1, 3);
    if (r == 17) return 4;
    return $urandom_range(5, 6);
  endfunction

  task automatic send_run_bytes(input int n);
    logic [7:0] b;
    for (int i = 1; i <= n; i++) begin
      b    = $urandom_range(0, 255);
      b[7] = (i < n);
      send_byte(b, 1'b0);
    end
  endtask

  task automatic send_coef_group();
    logic [7:0] lsb;
    logic [7:0] msb;
    logic       start;
    int         nrun;
    start = ($urandom_range(0, 15) == 0);
    nrun  = pick_run_count();
    lsb   = $urandom_range(0, 255);
    if (lsb[0]) begin
      send_byte(lsb, start);
      msb    = $urandom_range(0, 255);
      msb[7] = (nrun > 0);
      send_byte(msb, 1'b0);
    end else begin
      lsb[7] = (nrun > 0);
      send_byte(lsb, start);
    end
    send_run_bytes(nrun);
  endtask

  task automatic send_temporal_run();
    if ($urandom_range(0, 15) == 0) send_byte($urandom_range(0, 255), 1'b1);
    send_run_bytes(pick_run_count() + 1);
  endtask

  task automatic check_result(input result_t got);
    result_t exp_res;
    if (pending_results.size() == 0) begin
      report_error($sformatf("result with none expected: %h", got));
      return;
    end
    exp_res = pending_results.pop_front();
    if (got.coefficient !== exp_res.coefficient)
      report_error($sformatf("coefficient %0d, expected %0d",
                             got.coefficient, exp_res.coefficient));
    if (got.temporal_signal !== exp_res.temporal_signal)
      report_error($sformatf("temporal_signal %b, expected %b",
                             got.temporal_signal, exp_res.temporal_signal));
    if (got.run_length !== exp_res.run_length)
      report_error($sformatf("run_length %0d, expected %0d",
                             got.run_length, exp_res.run_length));
    if (got.run_overflow !== exp_res.run_overflow)
      report_error($sformatf("run_overflow %b, expected %b",
                             got.run_overflow, exp_res.run_overflow));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      check_result(result_t'(m_axis_tdata_o[rlectd_pkg::RES_W-1:0]));
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i) || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result sink: one wait per item, plus a requested long hold.
  initial begin
    int w;
    @(posedge rst_ni);
    forever begin
      w = rx_idle_on ? $urandom_range(0, 7) : 0;
      w += long_hold_cycles;
      long_hold_cycles = 0;
      if (w > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
    end
  end

  initial begin
    row_t  dir_rows[$];
    mode_e phase_mode;
    bit    paused;
    int    pick;

    error_count      = 0;
    phase_items      = 0;
    idle_cycles      = 0;
    long_hold_cycles = 0;
    tx_idle_on       = 1'b1;
    rx_idle_on       = 1'b1;
    dec_mode         = MODE_COEF;
    tmp_state        = 1'b0;
    clear_parse();

    // short extremes
    dir_rows.push_back(mk_row(ROW_RES,  8'h40, 1'b1, 0,     1'b0, 31'd0, 1'b0));
    dir_rows.push_back(mk_row(ROW_RES,  8'h00, 1'b0, -32,   1'b0, 31'd0, 1'b0));
    dir_rows.push_back(mk_row(ROW_RES,  8'h7E, 1'b0, 31,    1'b0, 31'd0, 1'b0));
    // long extremes
    dir_rows.push_back(mk_row(ROW_NONE, 8'h01, 1'b0, 0,     1'b0, 31'd0, 1'b0));
    dir_rows.push_back(mk_row(ROW_RES,  8'h00, 1'b0, -8192, 1'b0, 31'd0, 1'b0));
    dir_rows.push_back(mk_row(ROW_NONE, 8'hFF, 1'b0, 0,     1'b0, 31'd0, 1'b0));
    dir_rows.push_back(mk_row(ROW_RES,  8'h7F, 1'b0, 8191,  1'b0, 31'd0, 1'b0));
    // longest run that still fits
    dir_rows.push_back(mk_row(ROW_NONE, 8'hC2, 1'b0, 0,     1'b0, 31'd0, 1'b0));
    dir_rows.push_back(mk_row(ROW_NONE, 8'h87, 1'b0, 0,     1'b0, 31'd0, 1'b0));
    for (int i = 0; i < 3; i++)
      dir_rows.push_back(mk_row(ROW_NONE, 8'hFF, 1'b0, 0, 1'b0, 31'd0, 1'b0));
    dir_rows.push_back(mk_row(ROW_PRED, 8'h7F, 1'b0, 0,     1'b0, 31'd0, 1'b0));
    // long value followed by a saturating run
    dir_rows.push_back(mk_row(ROW_NONE, 8'h83, 1'b0, 0,     1'b0, 31'd0, 1'b0));
    dir_rows.push_back(mk_row(ROW_NONE, 8'h80, 1'b0, 0,     1'b0, 31'd0, 1'b0));
    for (int i = 0; i < 5; i++)
      dir_rows.push_back(mk_row(ROW_NONE, 8'hFF, 1'b0, 0, 1'b0, 31'd0, 1'b0));
    dir_rows.push_back(mk_row(ROW_RES,  8'h00, 1'b0, -8127, 1'b0, 31'h7FFF_FFFF, 1'b1));
    // new chunk drops a half-read long value
    dir_rows.push_back(mk_row(ROW_NONE, 8'h81, 1'b0, 0,     1'b0, 31'd0, 1'b0));
    dir_rows.push_back(mk_row(ROW_RES,  8'h42, 1'b1, 1,     1'b0, 31'd0, 1'b0));
    // temporal runs: state byte, then runs with alternating state
    dir_rows.push_back(mk_row(ROW_CFG,  8'h01, 1'b0, 0,     1'b0, 31'd0, 1'b0));
    dir_rows.push_back(mk_row(ROW_NONE, 8'h01, 1'b1, 0,     1'b0, 31'd0, 1'b0));
    dir_rows.push_back(mk_row(ROW_RES,  8'h05, 1'b0, 0,     1'b1, 31'd5, 1'b0));
    dir_rows.push_back(mk_row(ROW_NONE, 8'h81, 1'b0, 0,     1'b0, 31'd0, 1'b0));
    dir_rows.push_back(mk_row(ROW_RES,  8'h00, 1'b0, 0,     1'b0, 31'd128, 1'b0));
    dir_rows.push_back(mk_row(ROW_NONE, 8'hFE, 1'b1, 0,     1'b0, 31'd0, 1'b0));
    dir_rows.push_back(mk_row(ROW_RES,  8'h7F, 1'b0, 0,     1'b0, 31'd127, 1'b0));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) write_mode(dir_rows[i].symbol[0]);
      else send_row(dir_rows[i]);
    end

    for (int p = 0; p < PHASES; p++) begin
      phase_mode = mode_e'(PHASE_MODES[p]);
      write_mode(phase_mode);
      tx_idle_on  = (p != 2) && (p != 3);
      rx_idle_on  = (p != 2);
      phase_items = 0;
      paused      = 1'b0;
      // hold the sink while bytes keep coming so the output stage backs up
      if (p == 3) long_hold_cycles = 150;
      while (phase_items < PHASE_ITEMS) begin
        if (p == 5 && !paused && phase_items >= PHASE_ITEMS / 2) begin
          s_axis_tvalid_i <= 1'b0;
          wait_drained();
          paused = 1'b1;
        end
        pick = $urandom_range(0, 9);
        if (pick == 0) send_byte($urandom_range(0, 255), $urandom_range(0, 1));
        else if (phase_mode == MODE_COEF) send_coef_group();
        else send_temporal_run();
      end
    end

    s_axis_tvalid_i <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/rlectd_pkg.sv
rtl/core/rlectd_decode.sv
rtl/core/rle_coefficient_temporal_decoder_top.sv
sim/tb.sv
